>>> rtl/pqs_pkg.sv
// Package for the periodic query scheduler: payload structs, status codes,
// controller states and command/status structs. No dependencies.
package pqs_pkg;

  localparam int unsigned MaxEntries = 1024;
  localparam int unsigned AddrW      = $clog2(MaxEntries);
  localparam int unsigned CountW     = $clog2(MaxEntries + 1);
  localparam logic [31:0] DueMax     = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    StRegistered = 2'd0,
    StFired      = 2'd1,
    StFull       = 2'd2,
    StEmpty      = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    ActRegister = 1'b0,
    ActFire     = 1'b1
  } action_e;

  typedef struct packed {
    logic        action;
    logic [15:0] query_id;
    logic [15:0] period_len;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] fired_id;
    logic [31:0] fire_time;
  } out_item_t;

  // One heap slot: due time, id, period (compare order top to bottom)
  typedef struct packed {
    logic [31:0] due;
    logic [15:0] id;
    logic [15:0] period;
  } entry_t;

  typedef enum logic [3:0] {
    SIdle,
    SUpRd,     // read parent of pos
    SUpWait,
    SUpCmp,
    SDnRd,     // read left child
    SDnRdR,    // read right child
    SDnWait,
    SDnCmp,
    SDone
  } state_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic load_reg;   // start insert with input item
    logic load_fire;  // start fire: take root, advance due
    logic rd_root;    // read heap root ahead of a fire
    logic rd_parent;
    logic rd_left;
    logic rd_right;
    logic up_step;    // swap pos with parent if smaller
    logic dn_step;    // swap pos with best child if smaller
    logic set_result;
    logic publish;    // copy result into the output register
    logic [1:0] res_status;
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic full;
    logic empty;
    logic at_root;
    logic up_swap;    // cur smaller than parent
    logic has_left;
    logic dn_swap;    // a child is smaller than cur
  } stat_t;

  function automatic logic entry_before(entry_t a, entry_t b);
    return a < b;
  endfunction

endpackage

>>> rtl/pqs_datapath.sv
// Datapath: heap memory, current entry, position, count and result register.
// Depends on pqs_pkg.
module pqs_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pqs_pkg::in_item_t  in_i,
  input  pqs_pkg::cmd_t      cmd_i,
  output pqs_pkg::stat_t     stat_o,
  output pqs_pkg::out_item_t res_o
);

  pqs_pkg::entry_t mem [pqs_pkg::MaxEntries];

  logic [pqs_pkg::CountW-1:0] count_q, count_d;
  logic [pqs_pkg::AddrW-1:0]  pos_q, pos_d;
  pqs_pkg::entry_t            cur_q, cur_d;
  pqs_pkg::entry_t            rd_q, lc_q;
  pqs_pkg::out_item_t         res_q, res_d;
  pqs_pkg::out_item_t         pub_q;
  logic                       we;
  logic [pqs_pkg::AddrW-1:0]  wa, ra;
  pqs_pkg::entry_t            wd;
  logic                       re;

  // positions
  logic [pqs_pkg::AddrW-1:0] parent, left, right;
  logic [pqs_pkg::CountW:0]  left_w;
  assign parent = (pos_q - 1'b1) >> 1;
  assign left_w = {1'b0, pos_q, 1'b1};
  assign left   = left_w[pqs_pkg::AddrW-1:0];
  assign right  = left + 1'b1;

  logic has_left, has_right;
  assign has_left  = left_w < {1'b0, count_q};
  assign has_right = (left_w + 1'b1) < {1'b0, count_q};

  // best child selection uses lc_q (left) and rd_q (right)
  logic            pick_right;
  pqs_pkg::entry_t best;
  assign pick_right = has_right && pqs_pkg::entry_before(rd_q, lc_q);
  assign best       = pick_right ? rd_q : lc_q;

  assign stat_o.full    = count_q == pqs_pkg::CountW'(pqs_pkg::MaxEntries);
  assign stat_o.empty   = count_q == '0;
  assign stat_o.at_root = pos_q == '0;
  assign stat_o.up_swap = pqs_pkg::entry_before(cur_q, rd_q);
  assign stat_o.has_left = has_left;
  assign stat_o.dn_swap = pqs_pkg::entry_before(best, cur_q);

  // Memory read address
  always_comb begin
    re = 1'b1;
    ra = parent;
    if (cmd_i.rd_left) ra = left;
    else if (cmd_i.rd_right) ra = right;
    else if (cmd_i.load_fire || cmd_i.rd_root) ra = '0;
    else if (!cmd_i.rd_parent) re = 1'b0;
  end

  logic [32:0] sum;
  pqs_pkg::entry_t root;
  assign root = rd_q;
  assign sum  = {1'b0, root.due} + {17'd0, root.period};

  // Next-state datapath logic
  always_comb begin
    count_d = count_q;
    pos_d   = pos_q;
    cur_d   = cur_q;
    res_d   = res_q;
    we      = 1'b0;
    wa      = pos_q;
    wd      = cur_q;
    if (cmd_i.load_reg) begin
      cur_d   = '{due: {16'd0, in_i.period_len}, id: in_i.query_id,
                  period: in_i.period_len};
      pos_d   = count_q[pqs_pkg::AddrW-1:0];
      count_d = count_q + 1'b1;
    end
    if (cmd_i.load_fire) begin
      // rd_q holds root (read in previous cycle by controller)
      cur_d = root;
      cur_d.due = sum[32] ? pqs_pkg::DueMax : sum[31:0];
      pos_d = '0;
      res_d = '{status: pqs_pkg::StFired, fired_id: root.id, fire_time: root.due};
    end
    if (cmd_i.up_step) begin
      we = 1'b1;
      if (!stat_o.at_root && stat_o.up_swap) begin
        wd    = rd_q;
        pos_d = parent;
      end
    end
    if (cmd_i.dn_step) begin
      we = 1'b1;
      if (has_left && stat_o.dn_swap) begin
        wd    = best;
        pos_d = pick_right ? right : left;
      end
    end
    if (cmd_i.set_result)
      res_d = '{status: cmd_i.res_status, fired_id: '0, fire_time: '0};
  end

  // Heap memory, registered read
  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (re) rd_q <= mem[ra];
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    res_q <= res_d;
    if (cmd_i.rd_right) lc_q <= rd_q;
    if (cmd_i.publish) pub_q <= res_q;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pos_q   <= '0;
    end else begin
      count_q <= count_d;
      pos_q   <= pos_d;
    end
  end

  assign res_o = pub_q;

endmodule

>>> rtl/pqs_ctrl.sv
// Controller state machine sequencing insert sift-up and fire sift-down.
// Depends on pqs_pkg.
module pqs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              in_action_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  pqs_pkg::stat_t    stat_i,
  output pqs_pkg::cmd_t     cmd_o
);

  pqs_pkg::state_e state_q, state_d;
  logic            ov_q, ov_d;
  logic            fire_q, fire_d;   // fire: root read pending

  logic accept;
  assign in_stall_o  = (state_q != pqs_pkg::SIdle);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = ov_q;

  // Next state
  always_comb begin
    state_d = state_q;
    fire_d  = fire_q;
    ov_d    = ov_q && out_stall_i;
    unique case (state_q)
      pqs_pkg::SIdle: begin
        if (accept) begin
          if (in_action_i == pqs_pkg::ActRegister) begin
            state_d = stat_i.full ? pqs_pkg::SDone : pqs_pkg::SUpRd;
          end else if (stat_i.empty) begin
            state_d = pqs_pkg::SDone;
          end else begin
            state_d = pqs_pkg::SDnWait;
            fire_d  = 1'b1;
          end
        end
      end
      pqs_pkg::SUpRd:   state_d = stat_i.at_root ? pqs_pkg::SUpCmp : pqs_pkg::SUpWait;
      pqs_pkg::SUpWait: state_d = pqs_pkg::SUpCmp;
      pqs_pkg::SUpCmp:
        state_d = (!stat_i.at_root && stat_i.up_swap) ? pqs_pkg::SUpRd : pqs_pkg::SDone;
      pqs_pkg::SDnWait: begin
        fire_d  = 1'b0;
        state_d = fire_q ? pqs_pkg::SDnRd : pqs_pkg::SDnCmp;
      end
      pqs_pkg::SDnRd:   state_d = pqs_pkg::SDnRdR;
      pqs_pkg::SDnRdR:  state_d = pqs_pkg::SDnWait;
      pqs_pkg::SDnCmp:
        state_d = (stat_i.has_left && stat_i.dn_swap) ? pqs_pkg::SDnRd : pqs_pkg::SDone;
      pqs_pkg::SDone: begin
        // hand over once the output register is free
        if (!ov_q || !out_stall_i) begin
          ov_d    = 1'b1;
          state_d = pqs_pkg::SIdle;
        end
      end
      default: state_d = pqs_pkg::SIdle;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      pqs_pkg::SIdle: begin
        if (accept) begin
          if (in_action_i == pqs_pkg::ActRegister) begin
            cmd_o.set_result = 1'b1;
            cmd_o.res_status = stat_i.full ? pqs_pkg::StFull : pqs_pkg::StRegistered;
            cmd_o.load_reg   = !stat_i.full;
          end else if (stat_i.empty) begin
            cmd_o.set_result = 1'b1;
            cmd_o.res_status = pqs_pkg::StEmpty;
          end else begin
            cmd_o.rd_root = 1'b1;
          end
        end
      end
      pqs_pkg::SUpRd:   cmd_o.rd_parent = 1'b1;
      pqs_pkg::SUpCmp:  cmd_o.up_step   = 1'b1;
      pqs_pkg::SDnWait: cmd_o.load_fire = fire_q;
      pqs_pkg::SDnRd:   cmd_o.rd_left   = 1'b1;
      pqs_pkg::SDnRdR:  cmd_o.rd_right  = 1'b1;
      pqs_pkg::SDnCmp:  cmd_o.dn_step   = 1'b1;
      pqs_pkg::SDone:   cmd_o.publish   = !ov_q || !out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pqs_pkg::SIdle;
      ov_q    <= 1'b0;
      fire_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      fire_q  <= fire_d;
    end
  end

endmodule

>>> rtl/periodic_query_scheduler_top.sv
// Top level of the periodic query scheduler: controller plus datapath.
// Depends on pqs_pkg, pqs_ctrl, pqs_datapath.
//
// Binary min-heap of up to 1024 periodic queries ordered by due time, then
// id, then period. Register inserts with due time equal to its period and
// sifts up; fire reports the root and reinserts it advanced by its period
// (saturating), sifting down. One transaction is worked on at a time. A
// register reads the parent, waits (not at the root) and compares at each
// heap level until it stops moving up; a fire first takes the root, then at
// each level reads both children, waits and compares; a full or empty answer
// goes straight to hand over. The result sits in its own output register, so
// the next transaction is taken while it waits; only a second finished result
// waits behind one that has not been accepted.
module periodic_query_scheduler_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pqs_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pqs_pkg::out_item_t out_data_o
);

  pqs_pkg::cmd_t  cmd;
  pqs_pkg::stat_t stat;

  pqs_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .in_action_i (in_data_i.action),
    .out_valid_o, .out_stall_i,
    .stat_i (stat), .cmd_o (cmd)
  );

  pqs_datapath u_dp (
    .clk_i, .rst_ni,
    .in_i (in_data_i), .cmd_i (cmd), .stat_o (stat), .res_o (out_data_o)
  );

endmodule

>>> rtl/pqs_checker.sv
// Port-level checker for the periodic query scheduler, bound to the top.
// Depends on pqs_pkg.
module pqs_port_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_i,
  input logic               out_valid_i,
  input logic               out_stall_i,
  input pqs_pkg::out_item_t out_data_i
);

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed under stall");

  // a valid result carries known data
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !$isunknown(out_data_i))
    else $error("result carries unknown bits");

  // id and time are zero unless fired
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status != pqs_pkg::StFired |->
      out_data_i.fired_id == '0 && out_data_i.fire_time == '0)
    else $error("non-fire result carries data");

  // an accepted transaction blocks the input next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i |=> in_stall_i)
    else $error("input not stalled after accept");

endmodule

bind periodic_query_scheduler_top pqs_port_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_i (in_stall_o),
  .out_valid_i (out_valid_o), .out_stall_i, .out_data_i (out_data_o)
);

>>> tb/pqs_checker.sv
// Checker for the periodic query scheduler: watches both channels, predicts
// each result from its own table of queries and compares. Depends on pqs_pkg.
module pqs_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  pqs_pkg::in_item_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  pqs_pkg::out_item_t out_data_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 fired_o,
  output int                 dropped_o
);

  pqs_pkg::entry_t    query_tbl[$];   // queries held, unordered
  pqs_pkg::out_item_t due_results[$]; // results still to come

  // Work out the result of one transaction and update the table
  function automatic pqs_pkg::out_item_t schedule_step(pqs_pkg::in_item_t it);
    pqs_pkg::out_item_t r;
    int                 best;
    pqs_pkg::entry_t    e;
    r = '0;
    if (it.action == pqs_pkg::ActRegister) begin
      if (query_tbl.size() >= pqs_pkg::MaxEntries) begin
        r.status = pqs_pkg::StFull;
      end else begin
        e.due    = {16'h0, it.period_len};
        e.id     = it.query_id;
        e.period = it.period_len;
        query_tbl.push_back(e);
        r.status = pqs_pkg::StRegistered;
      end
    end else if (query_tbl.size() == 0) begin
      r.status = pqs_pkg::StEmpty;
    end else begin
      best = 0;
      for (int i = 1; i < query_tbl.size(); i++)
        if (query_tbl[i] < query_tbl[best]) best = i;
      e           = query_tbl[best];
      r.status    = pqs_pkg::StFired;
      r.fired_id  = e.id;
      r.fire_time = e.due;
      // saturating advance
      if (e.due > pqs_pkg::DueMax - {16'h0, e.period}) e.due = pqs_pkg::DueMax;
      else e.due = e.due + {16'h0, e.period};
      query_tbl[best] = e;
    end
    return r;
  endfunction

  assign pending_o = due_results.size();

  // Predict on input transactions, compare output transactions
  always @(posedge clk_i or negedge rst_ni) begin
    pqs_pkg::out_item_t exp_r;
    int                 bad;
    bad = 0;
    if (!rst_ni) begin
      errors_o  <= 0;
      fired_o   <= 0;
      dropped_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) due_results.push_back(schedule_step(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          $error("result with nothing expected: status %0d", out_data_i.status);
          bad = 1;
        end else begin
          exp_r = due_results.pop_front();
          if (exp_r.status == pqs_pkg::StFired) fired_o <= fired_o + 1;
          if (exp_r.status == pqs_pkg::StFull) dropped_o <= dropped_o + 1;
          if (out_data_i.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, out_data_i.status);
            bad++;
          end
          if (out_data_i.fired_id !== exp_r.fired_id) begin
            $error("fired_id: expected %0d, got %0d", exp_r.fired_id,
                   out_data_i.fired_id);
            bad++;
          end
          if (out_data_i.fire_time !== exp_r.fire_time) begin
            $error("fire_time: expected %0d, got %0d", exp_r.fire_time,
                   out_data_i.fire_time);
            bad++;
          end
        end
      end
      errors_o <= errors_o + bad;
    end
  end

endmodule

>>> tb/tb.sv
// Testbench top for the periodic query scheduler: clock, reset, stimulus,
// stall pattern, watchdog and verdict. Depends on pqs_pkg, pqs_checker, RTL.
module tb;

  localparam int StallLimit = 20000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  pqs_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  pqs_pkg::out_item_t out_data;
  int                 errors, pending, fired_cnt, dropped_cnt;
  int                 idle_pct = 0;
  int                 stall_pct = 0;
  int                 quiet_cycles = 0;
  int                 sent = 0;

  periodic_query_scheduler_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  pqs_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .errors_o(errors), .pending_o(pending), .fired_o(fired_cnt),
    .dropped_o(dropped_cnt)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Receiver stall pattern
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallLimit) begin
      $display("periodic_query_scheduler_top test failed");
      $finish;
    end
  end

  // Send one transaction, with random idle gaps in front
  task automatic send_query(logic act, logic [15:0] qid, logic [15:0] per);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      in_data  <= '{action: 1'($urandom), query_id: 16'($urandom),
                    period_len: 16'($urandom)};
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{action: act, query_id: qid, period_len: per};
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_random(int reg_pct);
    logic [15:0] per;
    per = 16'($urandom_range(65535, 1));
    if ($urandom_range(3) == 0) per = 16'($urandom_range(64, 1)); // dense due times
    send_query($urandom_range(99) >= reg_pct, 16'($urandom), per);
  endtask

  task automatic set_pressure(int ip, int sp);
    idle_pct  = ip;
    stall_pct = sp;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fire on an empty table, then one long-period query fired a few times
    send_query(pqs_pkg::ActFire, 16'hFFFF, 16'hFFFF);
    send_query(pqs_pkg::ActRegister, 16'hA5A5, 16'hFFFF);
    for (int i = 0; i < 4; i++) send_query(pqs_pkg::ActFire, 16'h0000, 16'h0001);

    // Extremes of id and period, and ties on due time
    send_query(pqs_pkg::ActRegister, 16'hFFFF, 16'h0001);
    send_query(pqs_pkg::ActRegister, 16'h0000, 16'h0001);
    send_query(pqs_pkg::ActRegister, 16'h0007, 16'h0002);
    send_query(pqs_pkg::ActRegister, 16'h0003, 16'h0002);
    send_query(pqs_pkg::ActRegister, 16'h0003, 16'h0001);
    for (int i = 0; i < 10; i++)
      send_query(pqs_pkg::ActFire, 16'($urandom), 16'($urandom));

    // Random mix across the idling phases
    for (int ph = 0; ph < 4; ph++) begin
      unique case (ph)
        1: set_pressure(60, 0);
        2: set_pressure(0, 60);
        3: set_pressure(17, 17);
        default: set_pressure(0, 0);
      endcase
      for (int i = 0; i < 200; i++) send_random(55);
    end

    // Zero period sticks at due time 0 once registered
    send_query(pqs_pkg::ActRegister, 16'h0001, 16'h0000);
    for (int i = 0; i < 4; i++)
      send_query(pqs_pkg::ActFire, 16'($urandom), 16'($urandom));

    // Fill the table and push on past full
    set_pressure(17, 17);
    for (int i = 0; i < 1030; i++) send_random(100);
    for (int i = 0; i < 40; i++) send_random(50);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("Sent %0d transactions: %0d fires checked, %0d registers dropped as full,",
             sent, fired_cnt, dropped_cnt);
    $display("covering empty, full, ties and zero period under idling and stalls.");
    if (errors == 0) begin
      $display("periodic_query_scheduler_top test passed");
    end else begin
      $display("periodic_query_scheduler_top test failed");
    end
    $finish;
  end

endmodule
